// File: src/assert_macros.svh
// Assertion macros used by the top RTL file of the ISO-TP receive block.
// Depends on nothing; each user supplies a clk and an active-low arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while in reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/isotp_pkg.sv
// Package for the ISO-TP receive reassembler: sizes, codes, word layouts,
// controller states and the command/status bundles. Depends on nothing.
package isotp_pkg;

	localparam int MAX_MESSAGE_BYTES = 4096;
	localparam int ADDR_W            = $clog2(MAX_MESSAGE_BYTES);
	localparam int LEN_W             = 13;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE_BYTES);

	typedef logic [7:0] byte_t;

	// action codes
	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// frame kinds (high nibble of byte0)
	localparam logic [3:0] KIND_SINGLE = 4'd0;
	localparam logic [3:0] KIND_FIRST  = 4'd1;
	localparam logic [3:0] KIND_CONSEC = 4'd2;

	// result status codes
	localparam logic [1:0] STAT_PROGRESS = 2'd0;
	localparam logic [1:0] STAT_COMPLETE = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_BADSEQ   = 2'd3;

	localparam logic [3:0]       SF_MAX_LEN   = 4'd7;
	localparam logic [2:0]       FF_DATA_LEN  = 3'd6;
	localparam logic [2:0]       CF_DATA_LEN  = 3'd7;
	localparam logic [LEN_W-1:0] FF_COUNT     = LEN_W'(6);
	localparam logic [LEN_W-1:0] CF_CHUNK_MAX = LEN_W'(7);
	localparam logic [3:0]       SEQ_FIRST    = 4'd1;

	// input word: read_index, then byte0..byte7, zero pad on top
	typedef struct packed {
		logic [3:0]       pad;
		byte_t [7:0]      frame;
		logic [11:0]      read_index;
	} in_word_t;

	// output word: status lowest, zero pad on top
	typedef struct packed {
		logic [2:0]       pad;
		byte_t            read_data;
		logic [LEN_W-1:0] bytes_received;
		logic [LEN_W-1:0] message_length;
		logic             send_flow_control;
		logic [1:0]       status;
	} out_word_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_WRITE,
		FSM_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic write;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic wr_needed;
		logic wr_last;
	} dp_sts_t;

endpackage

// File: src/isotp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; no reset on the array or the read register.
module isotp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/isotp_ctrl.sv
// Controller state machine of the ISO-TP receive reassembler.
// Depends on isotp_pkg; drives the datapath by dp_cmd_t, reads dp_sts_t.
module isotp_ctrl
	import isotp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output fsm_state_t fsm_state
);

	fsm_state_t state_q, state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				state_d = sts.wr_needed ? FSM_WRITE : FSM_FINISH;
			end
			FSM_WRITE: begin
				if (sts.wr_last) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
			end
			FSM_WRITE: begin
				cmd.write = 1'b1;
			end
			FSM_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign fsm_state = state_q;

endmodule

// File: src/isotp_dp.sv
// Datapath of the ISO-TP receive reassembler: frame decode, message state,
// payload byte store and output word. Depends on isotp_pkg and isotp_ram.
module isotp_dp
	import isotp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  in_word_t  in_word,
	input  logic      in_action,
	output out_word_t out_word,
	output logic      ram_we
);

	// captured item
	logic        action_q;
	logic [11:0] rd_idx_q;
	byte_t       frame_q [8];

	// message state
	logic [LEN_W-1:0] tot_len_q;
	logic [LEN_W-1:0] rcv_cnt_q;
	logic [3:0]       exp_seq_q;

	// per-item results and write burst
	logic [1:0]       status_q;
	logic             fc_q;
	logic             rd_ok_q;
	logic [2:0]       wr_len_q;
	logic [2:0]       wr_src_q;
	logic [2:0]       wr_idx_q;
	logic [LEN_W-1:0] wr_base_q;
	out_word_t        out_q;

	// decode
	logic [3:0]       kind;
	logic [3:0]       low;
	logic [LEN_W-1:0] ff_total;
	logic [LEN_W-1:0] remain;
	logic [2:0]       chunk;
	logic [1:0]       status_d;
	logic             fc_d;
	logic [LEN_W-1:0] tot_len_d;
	logic [LEN_W-1:0] rcv_cnt_d;
	logic [3:0]       exp_seq_d;
	logic [2:0]       wr_len_d;
	logic [2:0]       wr_src_d;
	logic [LEN_W-1:0] wr_base_d;

	logic [LEN_W-1:0]  wr_addr;
	logic [2:0]        wr_sel;
	logic              ram_re;
	byte_t             ram_rdata;

	assign kind     = frame_q[0][7:4];
	assign low      = frame_q[0][3:0];
	assign ff_total = {1'b0, low, frame_q[1]};
	assign remain   = tot_len_q - rcv_cnt_q;

	always_comb begin
		if (rcv_cnt_q >= tot_len_q) begin
			chunk = 3'd0;
		end else if (remain >= CF_CHUNK_MAX) begin
			chunk = CF_DATA_LEN;
		end else begin
			chunk = remain[2:0];
		end
	end

	always_comb begin
		status_d  = STAT_PROGRESS;
		fc_d      = 1'b0;
		tot_len_d = tot_len_q;
		rcv_cnt_d = rcv_cnt_q;
		exp_seq_d = exp_seq_q;
		wr_len_d  = 3'd0;
		wr_src_d  = 3'd1;
		wr_base_d = '0;
		if (action_q == ACT_FRAME) begin
			case (kind)
				KIND_SINGLE: begin
					if (low == 4'd0 || low > SF_MAX_LEN) begin
						status_d = STAT_OVERFLOW;
					end else begin
						status_d  = STAT_COMPLETE;
						wr_len_d  = low[2:0];
						tot_len_d = LEN_W'(low);
						rcv_cnt_d = LEN_W'(low);
					end
				end
				KIND_FIRST: begin
					if (ff_total > MAX_LEN) begin
						status_d = STAT_OVERFLOW;
					end else begin
						fc_d      = 1'b1;
						wr_len_d  = FF_DATA_LEN;
						wr_src_d  = 3'd2;
						tot_len_d = ff_total;
						rcv_cnt_d = FF_COUNT;
						exp_seq_d = SEQ_FIRST;
					end
				end
				KIND_CONSEC: begin
					if (low != exp_seq_q) begin
						status_d = STAT_BADSEQ;
					end else begin
						wr_len_d  = chunk;
						wr_base_d = rcv_cnt_q;
						rcv_cnt_d = rcv_cnt_q + LEN_W'(chunk);
						exp_seq_d = exp_seq_q + 4'd1;
						// done when nothing was missing or the rest fit in this frame
						if (rcv_cnt_q >= tot_len_q || remain <= CF_CHUNK_MAX) begin
							status_d = STAT_COMPLETE;
						end
					end
				end
				default: begin
					status_d = STAT_BADSEQ;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_len_q <= '0;
			rcv_cnt_q <= '0;
			exp_seq_q <= '0;
			wr_idx_q  <= '0;
			wr_len_q  <= '0;
		end else begin
			if (cmd.exec) begin
				tot_len_q <= tot_len_d;
				rcv_cnt_q <= rcv_cnt_d;
				exp_seq_q <= exp_seq_d;
				wr_len_q  <= wr_len_d;
				wr_idx_q  <= '0;
			end else if (cmd.write) begin
				wr_idx_q <= wr_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			rd_idx_q <= in_word.read_index;
			for (int i = 0; i < 8; i++) begin
				frame_q[i] <= in_word.frame[i];
			end
		end
		if (cmd.exec) begin
			status_q  <= status_d;
			fc_q      <= fc_d;
			wr_src_q  <= wr_src_d;
			wr_base_q <= wr_base_d;
			rd_ok_q   <= {1'b0, rd_idx_q} < MAX_LEN;
		end
		if (cmd.load_out) begin
			out_q.pad               <= '0;
			out_q.status            <= status_q;
			out_q.send_flow_control <= fc_q;
			out_q.message_length    <= tot_len_q;
			out_q.bytes_received    <= rcv_cnt_q;
			out_q.read_data         <= (action_q == ACT_READ && rd_ok_q) ? ram_rdata : 8'd0;
		end
	end

	// write burst: one payload byte per cycle
	assign wr_addr = wr_base_q + LEN_W'(wr_idx_q);
	assign wr_sel  = wr_src_q + wr_idx_q;
	assign ram_we  = cmd.write && (wr_addr < MAX_LEN);
	assign ram_re  = cmd.exec && (action_q == ACT_READ);

	isotp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_MESSAGE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr[ADDR_W-1:0]),
		.wdata (frame_q[wr_sel]),
		.re    (ram_re),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign sts.wr_needed = (wr_len_d != 3'd0);
	assign sts.wr_last   = (wr_idx_q == wr_len_q - 3'd1);
	assign out_word      = out_q;

endmodule

// File: src/isotp_receive_reassembler_top.sv
// A word accepted in idle is decoded, its 0 to 7 payload bytes stored, then its result registered.
// One word at a time; the store takes one payload byte per cycle on its write port.
// A finished result waits in the output register while the next word is decoded.
// Reset (arst_n low, asynchronous) clears control and message counters; the byte store
// is not cleared and reads of never-written bytes are undefined.
module isotp_receive_reassembler_top
	import isotp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave side: one CAN frame or one read request per word
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // read_index[11:0], byte0..byte7 (8 bits each), 4 zero bits
	input  logic [0:0]  s_tuser,  // action: 0 frame, 1 read stored byte
	// master side: one result word per accepted input word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[1:0], send_flow_control, message_length[12:0],
	                              // bytes_received[12:0], read_data[7:0], 3 zero bits
);

	`include "assert_macros.svh"

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	fsm_state_t fsm_state;
	out_word_t  out_word;
	in_word_t   in_word;
	logic       ram_we;

	assign in_word = s_tdata;

	// Controller: accept in idle, decode, burst-write the payload, then hand off.
	isotp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.sts       (sts),
		.cmd       (cmd),
		.fsm_state (fsm_state)
	);

	// Datapath: frame decode, message counters, byte store and output register.
	isotp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.in_action (s_tuser[0]),
		.out_word  (out_word),
		.ram_we    (ram_we)
	);

	assign m_tdata = out_word;

	// An accepted word always goes to decode next.
	`ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, fsm_state == FSM_EXEC)
	// Store writes happen only during the write burst.
	`ASSERT_IMPL(a_write_in_burst, ram_we, fsm_state == FSM_WRITE)
	// Flow control is requested only with an in-progress status.
	`ASSERT_IMPL(a_fc_progress, m_tvalid && out_word.send_flow_control,
		out_word.status == STAT_PROGRESS)
	// The byte count never passes the store size.
	`ASSERT_IMPL(a_count_bound, m_tvalid, out_word.bytes_received <= MAX_LEN)

endmodule

// File: bench/tb_isotp_receive_reassembler_top.sv
`timescale 1ns / 1ps
// Self-checking bench for isotp_receive_reassembler_top: directed and random CAN frame words and
// store reads, checked word by word against a local reassembly predictor. Needs isotp_pkg.
module tb_isotp_receive_reassembler_top;
	import isotp_pkg::*;

	localparam logic [3:0]  KIND_FLOW      = 4'd3;    // flow-control type, rejected on receive
	localparam int unsigned ITEM_TARGET    = 1450;
	localparam int unsigned STALL_AT       = 400;     // result count at which the sink backs off
	localparam int unsigned LONG_STALL     = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned PRINT_CAP      = 40;

	// running message counters; the store contents are tracked separately
	typedef struct packed {
		logic [LEN_W-1:0] total;
		logic [LEN_W-1:0] count;
		logic [3:0]       seq;
		logic             rx_active;
	} msg_track_t;

	typedef struct packed {
		logic     act;
		in_word_t w;
	} bus_word_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// predictor state, advanced on every accepted input word
	msg_track_t  msg_state = '0;
	byte_t       payload_copy [MAX_MESSAGE_BYTES];
	out_word_t   expected_results [$];

	// generator view: same counters, plus how far the store is known to be written
	msg_track_t  gen_track = '0;
	int unsigned gen_hw    = 0;
	bus_word_t   pending_words [$];
	int unsigned total_words;

	int unsigned words_in    = 0;
	int unsigned results_out = 0;
	int unsigned mismatches  = 0;
	int unsigned stall_cycles = 0;

	isotp_receive_reassembler_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the message counters for one frame; return the status it earns.
	function automatic logic [1:0] track_frame(inout msg_track_t t, input logic [7:0] b0,
			input logic [7:0] b1, output logic fc);
		logic [3:0]       kind;
		logic [3:0]       low;
		logic [LEN_W-1:0] tot;
		logic [LEN_W-1:0] room;
		logic [1:0]       st;
		kind = b0[7:4];
		low  = b0[3:0];
		tot  = {1'b0, low, b1};
		fc   = 1'b0;
		st   = STAT_BADSEQ;
		case (kind)
		KIND_SINGLE: begin
			if (low == 4'd0 || low > SF_MAX_LEN) begin
				st = STAT_OVERFLOW;
			end else begin
				t.total     = LEN_W'(low);
				t.count     = LEN_W'(low);
				t.rx_active = 1'b0;
				st          = STAT_COMPLETE;
			end
		end
		KIND_FIRST: begin
			if (tot > MAX_LEN) begin
				st = STAT_OVERFLOW;
			end else begin
				t.total     = tot;
				t.count     = FF_COUNT;
				t.seq       = SEQ_FIRST;
				t.rx_active = 1'b1;
				fc          = 1'b1;
				st          = STAT_PROGRESS;
			end
		end
		KIND_CONSEC: begin
			if (b0[3:0] != t.seq) begin
				// wrong sequence: drop out of receiving, keep the counts
				t.rx_active = 1'b0;
				st          = STAT_BADSEQ;
			end else begin
				room    = (t.count < t.total) ? t.total - t.count : '0;
				t.count = t.count + ((room > CF_CHUNK_MAX) ? CF_CHUNK_MAX : room);
				t.seq   = t.seq + 4'd1;
				if (t.count >= t.total) begin
					t.rx_active = 1'b0;
					st          = STAT_COMPLETE;
				end else begin
					st = STAT_PROGRESS;
				end
			end
		end
		default: st = STAT_BADSEQ;
		endcase
		return st;
	endfunction

	// Expected result word for one accepted input word; updates the predictor state.
	function automatic out_word_t reassemble_step(logic act, in_word_t w);
		out_word_t  r;
		msg_track_t prev;
		logic       fc;
		int unsigned p;
		r    = '0;
		prev = msg_state;
		if (act == ACT_READ) begin
			r.read_data = payload_copy[w.read_index];
		end else begin
			r.status = track_frame(msg_state, w.frame[0], w.frame[1], fc);
			r.send_flow_control = fc;
			case (w.frame[0][7:4])
			KIND_SINGLE: begin
				if (r.status == STAT_COMPLETE)
					for (p = 0; p < msg_state.count; p++) payload_copy[p] = w.frame[p + 1];
			end
			KIND_FIRST: begin
				if (fc)
					for (p = 0; p < FF_DATA_LEN; p++) payload_copy[p] = w.frame[p + 2];
			end
			KIND_CONSEC: begin
				if (r.status != STAT_BADSEQ)
					for (p = prev.count; p < msg_state.count; p++)
						payload_copy[p] = w.frame[p - prev.count + 1];
			end
			default: ;
			endcase
		end
		r.message_length = msg_state.total;
		r.bytes_received = msg_state.count;
		return r;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.pad        = '0;
		w.read_index = 12'($urandom);
		for (int k = 0; k < 8; k++) w.frame[k] = 8'($urandom);
		return w;
	endfunction

	// Queue one frame word; the rest of the frame and the read index are random.
	function automatic void add_frame(logic [7:0] b0, logic [7:0] b1);
		bus_word_t bw;
		logic      fc;
		bw.act         = ACT_FRAME;
		bw.w           = random_word();
		bw.w.frame[0]  = b0;
		bw.w.frame[1]  = b1;
		void'(track_frame(gen_track, b0, b1, fc));
		if (gen_track.count > gen_hw) gen_hw = gen_track.count;
		pending_words.push_back(bw);
	endfunction

	// Queue a store read; callers only pass positions already written.
	function automatic void add_read(logic [11:0] idx);
		bus_word_t bw;
		bw.act          = ACT_READ;
		bw.w            = random_word();
		bw.w.read_index = idx;
		pending_words.push_back(bw);
	endfunction

	function automatic void add_random_read();
		add_read(12'($urandom_range(0, gen_hw - 1)));
	endfunction

	// First frame plus consecutive frames until the total is in. A broken message
	// takes a wrong sequence number somewhere, then stops or carries on, or just stops.
	function automatic void add_message(int unsigned total, bit broken);
		logic [11:0] len;
		int unsigned cut;
		int unsigned sent;
		int unsigned how;
		len  = 12'(total);
		cut  = broken ? $urandom_range(0, 8) : 32'hFFFF_FFFF;
		sent = 0;
		add_frame({KIND_FIRST, len[11:8]}, len[7:0]);
		while (sent == 0 || gen_track.count < gen_track.total) begin
			if ($urandom_range(0, 5) == 0) add_random_read();
			if (sent == cut) begin
				how = $urandom_range(0, 2);
				if (how != 2)
					add_frame({KIND_CONSEC, gen_track.seq ^ 4'($urandom_range(1, 15))},
						8'($urandom));
				if (how != 1) return;
			end
			add_frame({KIND_CONSEC, gen_track.seq}, 8'($urandom));
			sent++;
		end
	endfunction

	// Per-word wait, drawn at random, with occasional stretches of back-to-back words.
	function automatic int unsigned pick_gap(inout int unsigned calm_left);
		int unsigned g;
		if (calm_left > 0) begin
			calm_left--;
			g = 0;
		end else if ($urandom_range(0, 24) == 0) begin
			calm_left = $urandom_range(20, 60);
			g = 0;
		end else begin
			g = $urandom_range(0, 10);
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned seen);
		if (mismatches < PRINT_CAP)
			$display("%0t: result %0d %s: expected %0d, got %0d", $time, results_out, what,
				want, seen);
		mismatches++;
	endtask

	// Sender: present each queued word after its drawn gap; hold it until accepted.
	bus_word_t   src_word;
	bit          offering  = 1'b0;
	int unsigned words_sent = 0;
	int unsigned src_gap   = 0;
	int unsigned src_calm  = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && words_in != words_sent) begin
				words_sent++;
				offering = 1'b0;
				src_gap  = pick_gap(src_calm);
			end
			if (!offering) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_words.size() > 0) begin
					src_word = pending_words.pop_front();
					s_tdata  <= src_word.w;
					s_tuser  <= src_word.act;
					offering = 1'b1;
				end
			end
			s_tvalid <= offering;
		end
	end

	// Sink: drop ready for a drawn number of cycles after each result word,
	// and once for a long stretch so the block backs up into its input.
	int unsigned results_taken = 0;
	int unsigned sink_hold = 0;
	int unsigned sink_calm = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (results_out != results_taken) begin
				results_taken = results_out;
				sink_hold = pick_gap(sink_calm);
				if (results_taken == STALL_AT) sink_hold = LONG_STALL;
			end else if (sink_hold > 0) begin
				sink_hold--;
			end
			m_tready <= (sink_hold == 0);
		end
	end

	// Monitor: check the result word first, then predict for the input word, so a
	// word accepted in the same cycle never pairs with that result.
	out_word_t got;
	out_word_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = out_word_t'(m_tdata);
				if (expected_results.size() == 0) begin
					report_mismatch("arrived with nothing pending, status", 0, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_mismatch("status", want.status, got.status);
					if (got.send_flow_control != want.send_flow_control)
						report_mismatch("send_flow_control", want.send_flow_control,
							got.send_flow_control);
					if (got.message_length != want.message_length)
						report_mismatch("message_length", want.message_length,
							got.message_length);
					if (got.bytes_received != want.bytes_received)
						report_mismatch("bytes_received", want.bytes_received,
							got.bytes_received);
					if (got.read_data != want.read_data)
						report_mismatch("read_data", want.read_data, got.read_data);
				end
				results_out <= results_out + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(reassemble_step(s_tuser[0], in_word_t'(s_tdata)));
				words_in <= words_in + 1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("isotp_receive_reassembler_top verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned len;

		// directed: single-frame extremes and bad lengths
		add_frame({KIND_SINGLE, 4'd1}, 8'h00);
		add_read(12'd0);
		add_frame({KIND_SINGLE, SF_MAX_LEN}, 8'hFF);
		add_frame({KIND_SINGLE, 4'd0}, 8'h00);
		add_frame({KIND_SINGLE, 4'd8}, 8'h00);
		add_frame({KIND_SINGLE, 4'hF}, 8'hFF);
		// consecutive frame while idle, with nothing left to receive
		add_frame({KIND_CONSEC, gen_track.seq}, 8'h5A);
		// first frames shorter than their own payload
		add_frame({KIND_FIRST, 4'd0}, 8'd3);
		add_frame({KIND_CONSEC, gen_track.seq}, 8'hA5);
		add_frame({KIND_FIRST, 4'd0}, 8'd0);
		add_frame({KIND_CONSEC, gen_track.seq}, 8'h00);
		// wrong sequence mid-message, then the right one is still taken
		add_frame({KIND_FIRST, 4'd0}, 8'd20);
		add_frame({KIND_CONSEC, gen_track.seq}, 8'h11);
		add_frame({KIND_CONSEC, gen_track.seq + 4'd1}, 8'h22);
		add_frame({KIND_CONSEC, gen_track.seq}, 8'h33);
		// matching frame after the message is complete
		add_frame({KIND_CONSEC, gen_track.seq}, 8'h44);
		add_read(12'd19);
		add_read(12'd5);
		// frame types outside the receive set
		add_frame({KIND_FLOW, 4'd0}, 8'h00);
		add_frame({4'hF, 4'h5}, 8'hFF);
		add_frame({4'h4, 4'hA}, 8'h00);

		// one message of the largest total the length field can carry
		add_message(4095, 1'b0);
		add_read(12'd4094);

		while (pending_words.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					len = $urandom_range(0, 6);
				else if (pick == 1)
					len = $urandom_range(200, 700);
				else
					len = $urandom_range(7, 60);
				add_message(len, $urandom_range(0, 5) == 0);
			end else if (pick < 14) begin
				add_frame({KIND_SINGLE, 4'($urandom_range(0, 15))}, 8'($urandom));
			end else if (pick < 16) begin
				add_random_read();
			end else if (pick < 19) begin
				add_frame(8'($urandom), 8'($urandom));
			end else begin
				add_frame({KIND_CONSEC, gen_track.seq}, 8'($urandom));
			end
		end
		total_words = pending_words.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (words_in != total_words || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("isotp_receive_reassembler_top verification clean");
		end else begin
			$display("isotp_receive_reassembler_top verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/isotp_pkg.sv
src/isotp_ram.sv
src/isotp_ctrl.sv
src/isotp_dp.sv
src/isotp_receive_reassembler_top.sv
bench/tb_isotp_receive_reassembler_top.sv
